// File: design/overcurrent_trip_auto_restart_top_macros.svh
// Assertion macros shared by the overcurrent trip checker.
`ifndef OVERCURRENT_TRIP_AUTO_RESTART_TOP_MACROS_SVH
`define OVERCURRENT_TRIP_AUTO_RESTART_TOP_MACROS_SVH

// Same-cycle implication, masked during reset.
`define OCRST_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("overcurrent trip check failed");

// Next-cycle implication, masked during reset.
`define OCRST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("overcurrent trip check failed");

// Next-cycle implication that is also checked across reset.
`define OCRST_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("overcurrent trip check failed");

`endif

// File: design/ocrst_pkg.sv
// Types and constants for the overcurrent trip with auto restart block.
`default_nettype none

package ocrst_pkg;

  localparam int unsigned THRESH_W = 8;
  localparam int unsigned RUN_W    = 4;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned INDEX_W  = 2;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd200;
  localparam logic [RUN_W-1:0]    LIMIT_RESET  = 4'd3;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1000;
  localparam logic [RUN_W-1:0]    RUN_MAX      = 4'd15;

  typedef enum logic [2:0] {
    KIND_SAMPLE    = 3'd0,
    KIND_TICK      = 3'd1,
    KIND_FORCE_RST = 3'd2,
    KIND_POWER_ON  = 3'd3,
    KIND_POWER_OFF = 3'd4
  } kind_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_TRIP_THRESHOLD = 2'd0,
    REG_TRIP_RUN_LIMIT = 2'd1,
    REG_RESTART_PERIOD = 2'd2
  } reg_index_t;

  // Result item, lowest field in the lowest bit.
  typedef struct packed {
    logic             timer_armed;
    logic             mission_clear;
    logic             restored;
    logic             tripped;
    logic [RUN_W-1:0] over_run;
    logic             power_enabled;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);
  localparam int unsigned OUT_W    = 16;

endpackage

`default_nettype wire

// File: design/overcurrent_trip_auto_restart_top.sv
// Top level of the overcurrent trip with auto restart block.
//
//  channel   dir  handshake             payload
//  s_*       in   s_tvalid / s_tready   tuser: kind, tdata: current_sample
//  m_*       out  m_tvalid / m_tready   tdata: result fields
//  cfg_*     in   cfg_we                cfg_index, cfg_data
//
// One item per clock sustained while m_tready is high; an item passes from its
// transaction to the input register, then via the state update to the result register.
// The run counter, restart count and rail state update in one pass.
// rst is synchronous: rail on, timer idle, counters clear, registers default.
// A stalled m_tready holds the result; the input register keeps filling
// until both stages are occupied.
`default_nettype none

module overcurrent_trip_auto_restart_top
  import ocrst_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,   // [7:0] current_sample
  input  wire logic [7:0]         s_tuser,   // [2:0] kind
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [OUT_W-1:0]        m_tdata,   // [0] power_enabled, [4:1] over_run,
                                             // [5] tripped, [6] restored,
                                             // [7] mission_clear, [8] timer_armed
  input  wire logic               cfg_we,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data
);

  logic [THRESH_W-1:0] trip_threshold;
  logic [RUN_W-1:0]    trip_run_limit;
  logic [PERIOD_W-1:0] restart_period;

  logic [RUN_W-1:0]    run_count, run_count_next;
  logic [PERIOD_W-1:0] restart_count, restart_count_next;
  logic                armed, armed_next;
  logic                rail_on, rail_on_next;

  logic                in_valid;
  logic [2:0]          in_kind;
  logic [THRESH_W-1:0] in_sample;

  logic                advance;
  result_t             result;
  logic [RUN_W-1:0]    run_upd;
  logic [PERIOD_W-1:0] count_inc;

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      trip_threshold <= THRESH_RESET;
      trip_run_limit <= LIMIT_RESET;
      restart_period <= PERIOD_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_TRIP_THRESHOLD: trip_threshold <= cfg_data[THRESH_W-1:0];
        REG_TRIP_RUN_LIMIT: trip_run_limit <= cfg_data[RUN_W-1:0];
        REG_RESTART_PERIOD: restart_period <= cfg_data[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind   <= s_tuser[2:0];
      in_sample <= s_tdata;
    end
  end

  // State update for the item held in the input register.
  always_comb begin
    run_count_next     = run_count;
    restart_count_next = restart_count;
    armed_next         = armed;
    rail_on_next       = rail_on;
    result             = '0;
    count_inc          = restart_count + PERIOD_W'(1);

    if (in_sample >= trip_threshold) begin
      run_upd = (run_count != RUN_MAX) ? run_count + RUN_W'(1) : run_count;
    end else begin
      run_upd = '0;
    end

    case (kind_t'(in_kind))
      KIND_SAMPLE: begin
        run_count_next = run_upd;
        if (run_upd > trip_run_limit) begin
          run_count_next = '0;
          rail_on_next   = 1'b0;
          armed_next     = 1'b1;
          result.tripped = 1'b1;
        end
      end
      KIND_TICK: begin
        if (armed) begin
          if (count_inc == restart_period) begin
            rail_on_next       = 1'b1;
            armed_next         = 1'b0;
            restart_count_next = '0;
            result.restored    = 1'b1;
          end else begin
            restart_count_next = count_inc;
          end
        end
      end
      KIND_FORCE_RST: begin
        rail_on_next   = 1'b0;
        armed_next     = 1'b1;
        result.tripped = 1'b1;
      end
      KIND_POWER_ON:  rail_on_next = 1'b1;
      KIND_POWER_OFF: rail_on_next = 1'b0;
      default: ;
    endcase

    result.power_enabled = rail_on_next;
    result.over_run      = run_count_next;
    result.mission_clear = result.tripped;
    result.timer_armed   = armed_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count     <= '0;
      restart_count <= '0;
      armed         <= 1'b0;
      rail_on       <= 1'b1;
      m_tvalid      <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
      if (in_valid) begin
        run_count     <= run_count_next;
        restart_count <= restart_count_next;
        armed         <= armed_next;
        rail_on       <= rail_on_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_tdata <= {(OUT_W - RESULT_W)'(0), result};
    end
  end

endmodule

`default_nettype wire

// File: design/ocrst_checker.sv
// Port-level checker for the overcurrent trip block, bound to the top level.
`default_nettype none
`include "overcurrent_trip_auto_restart_top_macros.svh"

module ocrst_checker
  import ocrst_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             m_tvalid,
  input wire logic             m_tready,
  input wire logic [OUT_W-1:0] m_tdata
);

  // A trip leaves the rail off with the timer running.
  `OCRST_ASSERT_NOW(a_trip_cuts, clk, rst, m_tvalid && m_tdata[5], !m_tdata[0] && m_tdata[8] && m_tdata[7])

  // A restore leaves the rail on with the timer stopped, never with a trip.
  `OCRST_ASSERT_NOW(a_restore_state, clk, rst, m_tvalid && m_tdata[6], m_tdata[0] && !m_tdata[8] && !m_tdata[5])

  // Hold a stalled result.
  `OCRST_ASSERT_NEXT(a_hold_stall, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // No result straight out of reset.
  `OCRST_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)

endmodule

bind overcurrent_trip_auto_restart_top ocrst_checker u_ocrst_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// File: tb/sv/rail_guard_check.sv
// Scoreboard for the overcurrent trip block: predicts every result and compares it.
`timescale 1ns / 100ps

module rail_guard_check
  import ocrst_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  input  wire logic               s_tready,
  input  wire logic [7:0]         s_tdata,
  input  wire logic [7:0]         s_tuser,
  input  wire logic               m_tvalid,
  input  wire logic               m_tready,
  input  wire logic [OUT_W-1:0]   m_tdata,
  input  wire logic               cfg_we,
  input  wire logic [INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_data,
  output int                      pending,
  output int                      fail_count
);

  // Configuration copy.
  logic [THRESH_W-1:0] threshold_q;
  logic [RUN_W-1:0]    run_limit_q;
  logic [PERIOD_W-1:0] period_q;

  // Rail guard state.
  logic [RUN_W-1:0]    run_q;
  logic [PERIOD_W-1:0] ticks_q;
  logic                armed_q;
  logic                rail_q;

  result_t rail_results[$];

  function automatic result_t step_rail_guard(input logic [2:0] kind_code,
                                              input logic [7:0] sample);
    result_t r;
    logic    cut;
    logic    back;
    cut  = 1'b0;
    back = 1'b0;
    case (kind_code)
      KIND_SAMPLE: begin
        if (sample >= threshold_q) begin
          if (run_q != RUN_MAX) run_q = run_q + 1'b1;
        end else begin
          run_q = '0;
        end
        if (run_q > run_limit_q) begin
          run_q   = '0;
          rail_q  = 1'b0;
          armed_q = 1'b1;
          cut     = 1'b1;
        end
      end
      KIND_TICK: begin
        if (armed_q) begin
          // Count wraps at 16 bits; a period already passed restores after the wrap.
          ticks_q = ticks_q + 1'b1;
          if (ticks_q == period_q) begin
            rail_q  = 1'b1;
            armed_q = 1'b0;
            ticks_q = '0;
            back    = 1'b1;
          end
        end
      end
      KIND_FORCE_RST: begin
        rail_q  = 1'b0;
        armed_q = 1'b1;
        cut     = 1'b1;
      end
      KIND_POWER_ON:  rail_q = 1'b1;
      KIND_POWER_OFF: rail_q = 1'b0;
      default: ;
    endcase
    r.power_enabled = rail_q;
    r.over_run      = run_q;
    r.tripped       = cut;
    r.restored      = back;
    r.mission_clear = cut;
    r.timer_armed   = armed_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      threshold_q = THRESH_RESET;
      run_limit_q = LIMIT_RESET;
      period_q    = PERIOD_RESET;
      run_q       = '0;
      ticks_q     = '0;
      armed_q     = 1'b0;
      rail_q      = 1'b1;
      fail_count  = 0;
      rail_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TRIP_THRESHOLD: threshold_q = cfg_data[THRESH_W-1:0];
          REG_TRIP_RUN_LIMIT: run_limit_q = cfg_data[RUN_W-1:0];
          REG_RESTART_PERIOD: period_q    = cfg_data[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[RESULT_W-1:0]);
        if (rail_results.size() == 0) begin
          fail_count++;
          $display("%0t ns: result with nothing expected, actual %h", $time, got);
        end else begin
          want = rail_results.pop_front();
          check_field("power_enabled", 16'(want.power_enabled), 16'(got.power_enabled));
          check_field("over_run", 16'(want.over_run), 16'(got.over_run));
          check_field("tripped", 16'(want.tripped), 16'(got.tripped));
          check_field("restored", 16'(want.restored), 16'(got.restored));
          check_field("mission_clear", 16'(want.mission_clear), 16'(got.mission_clear));
          check_field("timer_armed", 16'(want.timer_armed), 16'(got.timer_armed));
        end
      end
      if (s_tvalid && s_tready)
        rail_results.push_back(step_rail_guard(s_tuser[2:0], s_tdata));
    end
    pending = rail_results.size();
  end

endmodule

// File: tb/sv/overcurrent_trip_auto_restart_top_tb.sv
// Stimulus and verdict for the overcurrent trip with auto restart block.
`timescale 1ns / 100ps

module overcurrent_trip_auto_restart_top_tb;
  import ocrst_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 50;
  localparam logic [2:0] KIND_UNUSED_LOW = 3'd5;
  localparam logic [2:0] KIND_UNUSED_TOP = 3'd7;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = '0;
  logic [7:0]           s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic                 cfg_we    = 1'b0;
  logic [INDEX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data  = '0;

  int pending;
  int fail_count;
  int send_idle    = 0;
  int recv_stall   = 0;
  int quiet_cycles = 0;

  // Settings currently in the block, used to aim samples at the threshold.
  logic [THRESH_W-1:0] thr_now   = THRESH_RESET;
  logic [RUN_W-1:0]    limit_now = LIMIT_RESET;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  overcurrent_trip_auto_restart_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rail_guard_check guard_check (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .fail_count(fail_count)
  );

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("overcurrent_trip_auto_restart_top: mismatch");
        $finish;
      end
    end
  end

  // Present one item and hold it until the transaction completes.
  task automatic drive_item(input logic [2:0] kind_code, input logic [7:0] sample);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {5'b0, kind_code};
    s_tdata  <= sample;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Drop valid and wait for every outstanding result, plus the pipeline depth.
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_TRIP_THRESHOLD: thr_now   = value[THRESH_W-1:0];
      REG_TRIP_RUN_LIMIT: limit_now = value[RUN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic logic [7:0] pick_sample();
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 50) begin
      v = int'(thr_now) + int'($urandom_range(4)) - 2;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
    end else if (r < 62) begin
      return 8'd0;
    end else if (r < 74) begin
      return 8'hFF;
    end
    return 8'($urandom_range(255));
  endfunction

  task automatic drive_random_item();
    int r;
    r = $urandom_range(99);
    if (r < 55)      drive_item(KIND_SAMPLE, pick_sample());
    else if (r < 80) drive_item(KIND_TICK, 8'($urandom_range(255)));
    else if (r < 86) drive_item(KIND_FORCE_RST, 8'($urandom_range(255)));
    else if (r < 91) drive_item(KIND_POWER_ON, 8'($urandom_range(255)));
    else if (r < 96) drive_item(KIND_POWER_OFF, 8'($urandom_range(255)));
    else             drive_item(3'($urandom_range(7, 5)), 8'($urandom_range(255)));
  endtask

  task automatic run_phase(input logic [7:0] thr, input logic [3:0] limit,
                           input logic [15:0] period, input int mode);
    int n;
    settle();
    write_reg(REG_TRIP_THRESHOLD, CFG_W'(thr));
    write_reg(REG_TRIP_RUN_LIMIT, CFG_W'(limit));
    write_reg(REG_RESTART_PERIOD, period);
    case (mode)
      0: begin send_idle = 0;  recv_stall = 0;  end
      1: begin send_idle = 80; recv_stall = 0;  end
      2: begin send_idle = 0;  recv_stall = 80; end
      default: begin send_idle = 28; recv_stall = 28; end
    endcase
    n = 0;
    while (n < PHASE_ITEMS) begin
      if ($urandom_range(99) < 15) begin
        // Unbroken over-current run of limit plus one samples; trips unless the limit is RUN_MAX.
        for (int i = 0; i <= int'(limit_now); i++)
          drive_item(KIND_SAMPLE, 8'(int'(thr_now) + $urandom_range(255 - int'(thr_now))));
        n += int'(limit_now) + 1;
      end else begin
        drive_random_item();
        n++;
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // Reset settings: threshold 200, limit 3, period 1000.
    drive_item(KIND_SAMPLE, 8'hFF);
    drive_item(KIND_SAMPLE, 8'd0);
    drive_item(KIND_SAMPLE, 8'd200);
    drive_item(KIND_SAMPLE, 8'd199);
    drive_item(KIND_TICK, 8'hFF);
    drive_item(KIND_UNUSED_LOW, 8'h00);
    drive_item(KIND_UNUSED_TOP, 8'hFF);
    drive_item(KIND_POWER_OFF, 8'h00);
    drive_item(KIND_POWER_ON, 8'h00);
    drive_item(KIND_POWER_OFF, 8'h00);
    // Samples judged while the rail is off; fourth one trips.
    repeat (4) drive_item(KIND_SAMPLE, 8'd255);
    drive_item(KIND_FORCE_RST, 8'h00);
    drive_item(KIND_POWER_ON, 8'h00);
    settle();
    write_reg(REG_RESTART_PERIOD, 16'd2);
    repeat (3) drive_item(KIND_TICK, 8'($urandom_range(255)));

    // Periods ascend so an armed count never lands past the new period.
    run_phase(8'd200, 4'd3,  16'd1,     0);
    run_phase(8'd128, 4'd0,  16'd2,     1);
    run_phase(8'd0,   4'd15, 16'd3,     2);
    run_phase(8'd100, 4'd2,  16'd4,     3);
    run_phase(8'd1,   4'd1,  16'd5,     0);
    run_phase(8'd230, 4'd5,  16'd6,     1);
    run_phase(8'd64,  4'd3,  16'd10,    2);
    run_phase(8'd255, 4'd14, 16'd65535, 3);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("overcurrent_trip_auto_restart_top: match");
    else
      $display("overcurrent_trip_auto_restart_top: mismatch");
    $finish;
  end

endmodule
